>>> rtl/arpc_pkg.sv
// arp cache package: payload structs, table entry layout, operation codes,
// controller states and the command/status structs between controller and datapath
// no dependencies
package arpc_pkg;

    localparam int ENTRIES_DEF = 128;

    localparam int IP_W   = 32;
    localparam int MAC_W  = 48;
    localparam int AGE_W  = 8;
    localparam int CNT_W  = 8;
    localparam int FUNC_W = 2;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK   = 2'd2;

    localparam logic [AGE_W-1:0] TIMEOUT_RESET = 8'd15;
    localparam logic [AGE_W-1:0] AGE_MAX       = 8'd255;
    localparam logic [CNT_W-1:0] EXP_MAX       = 8'd255;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [IP_W-1:0]   ip_addr;
        logic [MAC_W-1:0]  mac_addr;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [MAC_W-1:0]  found_mac;
        logic              inserted;
        logic              table_full;
        logic [CNT_W-1:0]  expired_count;
    } t_out_item;

    typedef struct packed {
        logic              valid;
        logic [AGE_W-1:0]  age;
        logic [IP_W-1:0]   ip;
        logic [MAC_W-1:0]  mac;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_RESULT
    } t_state;

    typedef struct packed {
        logic start;
        logic clr_step;
        logic scan_step;
        logic ins_write;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic cnt_last;
        logic is_insert;
        logic out_busy;
    } t_status;

endpackage

>>> rtl/arp_cache_with_aging.sv
// arp cache with aging: every item scans the whole table, one entry per cycle
// through the single read port of the table ram
// a new item is taken only in idle, after the previous result has been loaded into the output register
// reset: timeout back to 15, then a clearing pass over every entry with no input taken
// depends on arpc_pkg, arpc_ctrl, arpc_dp
module arp_cache_with_aging #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  arpc_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output arpc_pkg::t_out_item         o_out_item,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [arpc_pkg::AGE_W-1:0]  i_cfg_data
);

    arpc_pkg::t_cmd    cmd;
    arpc_pkg::t_status status;

    assign o_cfg_ready = 1'b1;

    arpc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    arpc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

>>> rtl/arpc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module arpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/arpc_ctrl.sv
// arp cache controller: sequences clearing pass, table scan, insert write
// and result hand-off; depends on arpc_pkg
module arpc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  arpc_pkg::t_status i_status,
    output arpc_pkg::t_cmd    o_cmd
);

    arpc_pkg::t_state r_state;
    arpc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= arpc_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            arpc_pkg::ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = arpc_pkg::ST_IDLE;
                end
            end
            arpc_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = arpc_pkg::ST_SCAN;
                end
            end
            arpc_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.cnt_last) begin
                    n_state = arpc_pkg::ST_DRAIN;
                end
            end
            arpc_pkg::ST_DRAIN: begin
                n_state = i_status.is_insert ? arpc_pkg::ST_WRITE : arpc_pkg::ST_RESULT;
            end
            arpc_pkg::ST_WRITE: begin
                o_cmd.ins_write = 1'b1;
                n_state         = arpc_pkg::ST_RESULT;
            end
            arpc_pkg::ST_RESULT: begin
                if (!i_status.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = arpc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = arpc_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

>>> rtl/arpc_dp.sv
// arp cache datapath: scan counter, table ram, match/free/aging logic,
// timeout register and output register; depends on arpc_pkg and arpc_ram
module arpc_dp #(
    parameter int ENTRIES = arpc_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  arpc_pkg::t_cmd                i_cmd,
    output arpc_pkg::t_status             o_status,
    input  arpc_pkg::t_in_item            i_in_item,
    input  logic                          i_cfg_valid,
    input  logic [arpc_pkg::AGE_W-1:0]    i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output arpc_pkg::t_out_item           o_out_item
);

    localparam int AW = $clog2(ENTRIES);

    logic [AW-1:0]                 r_cnt;
    logic                          cnt_last;
    logic                          r_rd_vld;
    logic [AW-1:0]                 r_rd_addr;
    logic [arpc_pkg::AGE_W-1:0]    r_timeout;

    logic [arpc_pkg::FUNC_W-1:0]   r_func;
    logic [arpc_pkg::IP_W-1:0]     r_ip;
    logic [arpc_pkg::MAC_W-1:0]    r_mac;

    logic                          r_found;
    logic [arpc_pkg::MAC_W-1:0]    r_found_mac;
    logic                          r_have_free;
    logic [AW-1:0]                 r_free_idx;
    logic [arpc_pkg::CNT_W-1:0]    r_exp;

    logic                          r_out_valid;
    arpc_pkg::t_out_item           r_out;

    logic [arpc_pkg::ENTRY_W-1:0]  rd_data;
    arpc_pkg::t_entry              rd_entry;
    arpc_pkg::t_entry              wr_entry;
    logic                          we;
    logic [AW-1:0]                 waddr;
    logic [arpc_pkg::AGE_W-1:0]    age_inc;
    logic                          expire;
    logic                          is_tick;

    assign cnt_last = (r_cnt == AW'(ENTRIES - 1));
    assign rd_entry = arpc_pkg::t_entry'(rd_data);
    assign is_tick  = (r_func == arpc_pkg::FUNC_TICK);
    assign age_inc  = (rd_entry.age == arpc_pkg::AGE_MAX) ? arpc_pkg::AGE_MAX
                                                           : rd_entry.age + 8'd1;
    assign expire   = (age_inc > r_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_timeout   <= arpc_pkg::TIMEOUT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step || i_cmd.scan_step) begin
                r_cnt <= cnt_last ? '0 : r_cnt + AW'(1);
            end
            r_rd_vld <= i_cmd.scan_step;
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_addr <= r_cnt;
        if (i_cmd.start) begin
            r_func      <= i_in_item.func;
            r_ip        <= i_in_item.ip_addr;
            r_mac       <= i_in_item.mac_addr;
            r_found     <= 1'b0;
            r_found_mac <= '0;
            r_have_free <= 1'b0;
            r_free_idx  <= '0;
            r_exp       <= '0;
        end else if (r_rd_vld) begin
            case (r_func)
                arpc_pkg::FUNC_LOOKUP: begin
                    if (rd_entry.valid && rd_entry.ip == r_ip) begin
                        r_found     <= 1'b1;
                        r_found_mac <= rd_entry.mac;
                    end
                end
                arpc_pkg::FUNC_INSERT: begin
                    if (!rd_entry.valid && !r_have_free) begin
                        r_have_free <= 1'b1;
                        r_free_idx  <= r_rd_addr;
                    end
                end
                arpc_pkg::FUNC_TICK: begin
                    if (rd_entry.valid && expire && r_exp != arpc_pkg::EXP_MAX) begin
                        r_exp <= r_exp + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end
        if (i_cmd.load_out) begin
            r_out.found         <= r_found;
            r_out.found_mac     <= r_found_mac;
            r_out.inserted      <= (r_func == arpc_pkg::FUNC_INSERT) && r_have_free;
            r_out.table_full    <= (r_func == arpc_pkg::FUNC_INSERT) && !r_have_free;
            r_out.expired_count <= r_exp;
        end
    end

    // write port: clearing pass, insert, or tick write-back
    always_comb begin
        we       = 1'b0;
        waddr    = r_rd_addr;
        wr_entry = '0;
        if (i_cmd.clr_step) begin
            we    = 1'b1;
            waddr = r_cnt;
        end else if (i_cmd.ins_write) begin
            we             = r_have_free;
            waddr          = r_free_idx;
            wr_entry.valid = 1'b1;
            wr_entry.age   = '0;
            wr_entry.ip    = r_ip;
            wr_entry.mac   = r_mac;
        end else if (r_rd_vld && is_tick && rd_entry.valid) begin
            we             = 1'b1;
            waddr          = r_rd_addr;
            wr_entry.valid = !expire;
            wr_entry.age   = age_inc;
            wr_entry.ip    = rd_entry.ip;
            wr_entry.mac   = rd_entry.mac;
        end
    end

    arpc_ram #(
        .WIDTH (arpc_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wr_entry),
        .i_re    (i_cmd.scan_step),
        .i_raddr (r_cnt),
        .o_rdata (rd_data)
    );

    assign o_status.cnt_last  = cnt_last;
    assign o_status.is_insert = (r_func == arpc_pkg::FUNC_INSERT);
    assign o_status.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
